### rtl/sste_pkg.sv
package sste_pkg;

  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CNT_W       = 4;

  localparam logic [7:0] DOT_BIT   = 8'h80;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_EMIT
  } sste_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;    // process the accepted character
    logic emit;    // load the next write into the output register
    logic finish;  // clear count and flags for the next text
  } sste_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic k_last;
    logic out_free;
  } sste_stat_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h7E;
      4'd1:    g = 8'h30;
      4'd2:    g = 8'h6D;
      4'd3:    g = 8'h79;
      4'd4:    g = 8'h33;
      4'd5:    g = 8'h5B;
      4'd6:    g = 8'h5F;
      4'd7:    g = 8'h70;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h7B;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

### rtl/sste_ctrl.sv
module sste_ctrl
  import sste_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       last_char_i,
  output logic       in_stall_o,
  input  sste_stat_t stat_i,
  output sste_cmd_t  cmd_o
);

  sste_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_valid_i && last_char_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.cnt_zero) begin
          state_d = ST_COLLECT;
        end else if (stat_i.out_free && stat_i.k_last) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    case (state_q)
      ST_COLLECT: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      ST_EMIT: begin
        if (stat_i.cnt_zero) begin
          cmd_o.finish = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = stat_i.k_last;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

### rtl/sste_dpath.sv
module sste_dpath
  import sste_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_code_i,
  input  logic       out_stall_i,
  input  sste_cmd_t  cmd_i,
  output sste_stat_t stat_o,
  output logic       out_valid_o,
  output logic [3:0] digit_address_o,
  output logic [7:0] segment_pattern_o,
  output logic       last_write_o,
  output logic       glyphs_dropped_o
);

  localparam int unsigned CAPACITY = (DIGIT_COUNT < 1) ? 1 :
                                     ((DIGIT_COUNT > STORE_DEPTH) ? STORE_DEPTH : DIGIT_COUNT);

  logic [7:0]       store_q [STORE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             after_q, after_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       last_glyph_q, last_glyph_d;
  logic             out_valid_q, out_valid_d;
  logic [3:0]       addr_q;
  logic [7:0]       pat_q;
  logic             lastw_q, drop_q;

  logic             is_digit, is_dot, full;
  logic [7:0]       glyph;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_data;
  logic [CNT_W-1:0] cnt_m1, rd_pos;
  logic [CNT_W-1:0] k_p1;

  assign is_digit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign is_dot   = (char_code_i == CHAR_DOT);
  assign glyph    = digit_glyph(char_code_i[3:0]);
  assign full     = (count_q >= CNT_W'(CAPACITY));
  assign cnt_m1   = count_q - CNT_W'(1);
  assign k_p1     = k_q + CNT_W'(1);
  // writes go out newest glyph first
  assign rd_pos   = cnt_m1 - k_q;

  always_comb begin
    count_d      = count_q;
    after_d      = after_q;
    ovf_d        = ovf_q;
    last_glyph_d = last_glyph_q;
    k_d          = k_q;
    wr_en        = 1'b0;
    wr_idx       = count_q[IDX_W-1:0];
    wr_data      = glyph;
    if (cmd_i.take) begin
      after_d = 1'b0;
      if (is_digit) begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          wr_en        = 1'b1;
          last_glyph_d = glyph;
          count_d      = count_q + CNT_W'(1);
          after_d      = 1'b1;
        end
      end else if (is_dot) begin
        if (after_q && (count_q != '0)) begin
          // decimal point joins the digit just stored
          wr_en   = 1'b1;
          wr_idx  = cnt_m1[IDX_W-1:0];
          wr_data = last_glyph_q | DOT_BIT;
        end else if (full) begin
          ovf_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = DOT_BIT;
          count_d = count_q + CNT_W'(1);
        end
      end
    end
    if (cmd_i.emit) k_d = k_p1;
    if (cmd_i.finish) begin
      count_d = '0;
      after_d = 1'b0;
      ovf_d   = 1'b0;
      k_d     = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      after_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      k_q         <= k_d;
      after_q     <= after_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_glyph_q <= last_glyph_d;
    if (wr_en) store_q[wr_idx] <= wr_data;
    if (cmd_i.emit) begin
      addr_q  <= k_p1;
      pat_q   <= store_q[rd_pos[IDX_W-1:0]];
      lastw_q <= (k_p1 == count_q);
      drop_q  <= ovf_q;
    end
  end

  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.k_last   = (k_p1 == count_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign digit_address_o   = addr_q;
  assign segment_pattern_o = pat_q;
  assign last_write_o      = lastw_q;
  assign glyphs_dropped_o  = drop_q;

endmodule

### rtl/seven_segment_text_encoder_core.sv
// Seven-segment text encoder. Characters of a formatted text arrive one per beat, with
// last_char_i on the final one; digits become segment patterns, a '.' after a digit
// lights that digit's decimal point, any other '.' is a dot of its own, and everything
// else is ignored. Up to DIGIT_COUNT glyphs, clamped to 1..STORE_DEPTH, are held;
// extra ones are dropped and every write of that text reports glyphs_dropped_o. While
// collecting, one character is taken each cycle. After the last character the input
// stalls while the writes go out, newest glyph first at address 1, one write per cycle
// while the output side does not stall, from the single read port of the glyph buffer.
module seven_segment_text_encoder_core
  import sste_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] digit_address_o,
  output logic [7:0] segment_pattern_o,
  output logic       last_write_o,
  output logic       glyphs_dropped_o
);

  sste_cmd_t  cmd;
  sste_stat_t stat;

  sste_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_char_i (last_char_i),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sste_dpath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .char_code_i       (char_code_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .digit_address_o   (digit_address_o),
    .segment_pattern_o (segment_pattern_o),
    .last_write_o      (last_write_o),
    .glyphs_dropped_o  (glyphs_dropped_o)
  );

endmodule

### rtl/sste_checker.sv
module sste_checker
  import sste_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_char_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] digit_address_o,
  input logic       last_write_o
);

  // stalled beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat withdrawn under stall");

  // write addresses stay within the display
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_address_o != 4'd0) && (digit_address_o <= 4'(DIGIT_COUNT)))
    else $error("digit address out of range");

  // the burst holds off new characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_char_i |=> in_stall_o)
    else $error("input not stalled after last character");

  // a write that is not the last is followed at once by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_write_o |=> out_valid_o)
    else $error("burst broken before last write");

endmodule

bind seven_segment_text_encoder_core sste_checker #(
  .DIGIT_COUNT (DIGIT_COUNT)
) u_sste_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_char_i     (last_char_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .digit_address_o (digit_address_o),
  .last_write_o    (last_write_o)
);
